>>> hdl/mipd_pkg.sv
package mipd_pkg;

   // field widths fixed by the word formats
   localparam int IN_W = 21;
   localparam int DISP_W = 22;
   localparam int DIST_W = 46;
   localparam int ENTRY_W = 21;
   localparam int ROW_W = 3 * ENTRY_W;
   localparam int CSR_IDX_W = 2;
   localparam int AXIS_W = 2;

   localparam int COORD_FRAC_BITS_DEFAULT = 16;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_ROW_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_ROW_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_ROW_Z = 2'd2;

   // axis / box column codes
   localparam logic [AXIS_W-1:0] AXIS_A = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_B = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_C = 2'd2;

   // what the shared multiplier works on this cycle
   typedef enum logic [1:0] {
      MUL_NONE  = 2'd0,
      MUL_FIRST = 2'd1,
      MUL_MAC   = 2'd2,
      MUL_SQR   = 2'd3
   } mul_op_type;

   typedef struct packed {
      logic              load;
      mul_op_type        mul_op;
      logic [AXIS_W-1:0] row;
      logic [AXIS_W-1:0] col;
      logic              round_en;
      logic              commit;
   } dp_cmd_type;

   typedef struct packed {
      logic last_pair;
      logic rsp_busy;
   } dp_status_type;

endpackage

>>> hdl/mipd_ctrl.sv
module mipd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mipd_pkg::dp_status_type status,
   output mipd_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_CHECK = 4'b1000
   } state_type;

   // steps of one box row: three products, drain, round, square
   localparam logic [2:0] PH_MAC0  = 3'd0;
   localparam logic [2:0] PH_MAC1  = 3'd1;
   localparam logic [2:0] PH_MAC2  = 3'd2;
   localparam logic [2:0] PH_DRAIN = 3'd3;
   localparam logic [2:0] PH_ROUND = 3'd4;
   localparam logic [2:0] PH_SQR   = 3'd5;

   localparam logic [mipd_pkg::AXIS_W-1:0] LAST_ROW = mipd_pkg::AXIS_C;

   state_type                     state_ff, state_in;
   logic [mipd_pkg::AXIS_W-1:0]   row_ff, row_in;
   logic [2:0]                    phase_ff, phase_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      phase_in = phase_ff;
      cmd = '0;
      cmd.mul_op = mipd_pkg::MUL_NONE;
      cmd.row = row_ff;
      cmd.col = mipd_pkg::AXIS_A;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
               row_in = mipd_pkg::AXIS_A;
               phase_in = PH_MAC0;
            end
         end
         ST_RUN: begin
            unique case (phase_ff)
               PH_MAC0: begin
                  cmd.mul_op = mipd_pkg::MUL_FIRST;
                  cmd.col = mipd_pkg::AXIS_A;
               end
               PH_MAC1: begin
                  cmd.mul_op = mipd_pkg::MUL_MAC;
                  cmd.col = mipd_pkg::AXIS_B;
               end
               PH_MAC2: begin
                  cmd.mul_op = mipd_pkg::MUL_MAC;
                  cmd.col = mipd_pkg::AXIS_C;
               end
               PH_ROUND: cmd.round_en = 1'b1;
               PH_SQR:   cmd.mul_op = mipd_pkg::MUL_SQR;
               default:  cmd.mul_op = mipd_pkg::MUL_NONE;
            endcase
            if (phase_ff == PH_SQR) begin
               phase_in = PH_MAC0;
               if (row_ff == LAST_ROW) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_CHECK;
         ST_CHECK: begin
            // a last pair waits until the output register is free
            if (!(status.last_pair && status.rsp_busy)) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= mipd_pkg::AXIS_A;
         phase_ff <= PH_MAC0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         phase_ff <= phase_in;
      end
   end

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_RUN))
      else $error("accepted word did not start the sequence");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status.last_pair) |-> !status.rsp_busy)
      else $error("result committed while output register busy");

   a_drain_after_last_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |->
         $past(state_ff == ST_RUN && row_ff == LAST_ROW && phase_ff == PH_SQR))
      else $error("drain entered before all rows were squared");

endmodule

>>> hdl/mipd_datapath.sv
module mipd_datapath #(
   parameter int COORD_FRAC_BITS = mipd_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mipd_pkg::dp_cmd_type                cmd,
   output mipd_pkg::dp_status_type             status,
   input  logic                                csr_write_en,
   input  logic [mipd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mipd_pkg::ROW_W-1:0]          csr_wdata,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_first_a,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_first_b,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_first_c,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_second_a,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_second_b,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_second_c,
   input  logic                                req_last_pair,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mipd_pkg::DIST_W-1:0]         rsp_min_dist2,
   output logic signed [mipd_pkg::DISP_W-1:0]  rsp_disp_a,
   output logic signed [mipd_pkg::DISP_W-1:0]  rsp_disp_b,
   output logic signed [mipd_pkg::DISP_W-1:0]  rsp_disp_c
);

   localparam int F = COORD_FRAC_BITS;
   localparam int IN_W = mipd_pkg::IN_W;
   localparam int DISP_W = mipd_pkg::DISP_W;
   localparam int DIST_W = mipd_pkg::DIST_W;
   localparam int ENTRY_W = mipd_pkg::ENTRY_W;
   localparam int ROW_W = mipd_pkg::ROW_W;
   localparam int W_W = F + 1;
   localparam int T_W = (DISP_W + 1 > F + 1) ? DISP_W + 1 : F + 1;
   // |acc| <= 3 * 2^(ENTRY_W-1) * 2^F, so a rounded component never needs saturation
   localparam int ACC_W = ENTRY_W + F + 2;
   localparam int R_W = ACC_W - F;
   localparam int MA_W = (ENTRY_W > R_W) ? ENTRY_W : R_W;
   localparam int MB_W = (W_W > R_W) ? W_W : R_W;
   localparam int P_W = MA_W + MB_W;
   localparam int SUM_W = DIST_W + 1;

   localparam logic [T_W-1:0]   HALF_T = T_W'(1) << (F - 1);
   localparam logic [W_W-1:0]   HALF_W = W_W'(1) << (F - 1);
   localparam logic [ACC_W-1:0] HALF_A = ACC_W'(1) << (F - 1);

   logic [ROW_W-1:0]          box_row_ff [3];
   logic [IN_W-1:0]           first_v [3];
   logic [IN_W-1:0]           second_v [3];
   logic [DISP_W-1:0]         d_new [3];
   logic [W_W-1:0]            w_new [3];
   logic [T_W-1:0]            t_new [3];
   logic [DISP_W-1:0]         d_ff [3];
   logic [W_W-1:0]            w_ff [3];
   logic                      last_ff;

   logic [ROW_W-1:0]          row_sel;
   logic signed [ENTRY_W-1:0] h_sel;
   logic signed [W_W-1:0]     w_sel;
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [P_W-1:0]     prod_in, prod_ff;
   mipd_pkg::mul_op_type      ptag_ff;

   logic [ACC_W-1:0]          acc_ff, acc_in, rnd;
   logic signed [R_W-1:0]     r_ff;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [DIST_W-1:0]         pair_dist2;
   logic                      better;

   logic [DIST_W-1:0]         best_dist2_ff;
   logic [DISP_W-1:0]         best_disp_ff [3];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]         rsp_dist_ff;
   logic [DISP_W-1:0]         rsp_disp_ff [3];

   assign first_v[0] = req_first_a;
   assign first_v[1] = req_first_b;
   assign first_v[2] = req_first_c;
   assign second_v[0] = req_second_a;
   assign second_v[1] = req_second_b;
   assign second_v[2] = req_second_c;

   // difference and nearest-image wrap, round half up
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_new[i] = {second_v[i][IN_W-1], second_v[i]} - {first_v[i][IN_W-1], first_v[i]};
         t_new[i] = {{(T_W - DISP_W){d_new[i][DISP_W-1]}}, d_new[i]} + HALF_T;
         w_new[i] = {1'b0, t_new[i][F-1:0]} - HALF_W;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (cmd.row)
         mipd_pkg::AXIS_A: row_sel = box_row_ff[0];
         mipd_pkg::AXIS_B: row_sel = box_row_ff[1];
         mipd_pkg::AXIS_C: row_sel = box_row_ff[2];
         default:          row_sel = '0;
      endcase
      unique case (cmd.col)
         mipd_pkg::AXIS_A: begin
            h_sel = row_sel[ENTRY_W-1:0];
            w_sel = w_ff[0];
         end
         mipd_pkg::AXIS_B: begin
            h_sel = row_sel[2*ENTRY_W-1:ENTRY_W];
            w_sel = w_ff[1];
         end
         mipd_pkg::AXIS_C: begin
            h_sel = row_sel[3*ENTRY_W-1:2*ENTRY_W];
            w_sel = w_ff[2];
         end
         default: begin
            h_sel = '0;
            w_sel = '0;
         end
      endcase
      if (cmd.mul_op == mipd_pkg::MUL_SQR) begin
         mul_a = MA_W'(r_ff);
         mul_b = MB_W'(r_ff);
      end else begin
         mul_a = MA_W'(h_sel);
         mul_b = MB_W'(w_sel);
      end
      prod_in = mul_a * mul_b;
   end

   // the registered product lands in the cycle after it was issued
   always_comb begin
      acc_in = acc_ff;
      sum_in = sum_ff;
      unique case (ptag_ff)
         mipd_pkg::MUL_FIRST: acc_in = ACC_W'(prod_ff);
         mipd_pkg::MUL_MAC:   acc_in = acc_ff + ACC_W'(prod_ff);
         mipd_pkg::MUL_SQR:   sum_in = sum_ff + SUM_W'(prod_ff);
         default:             acc_in = acc_ff;
      endcase
      if (cmd.load) begin
         sum_in = '0;
      end
      rnd = acc_ff + HALF_A;
   end

   assign pair_dist2 = (sum_ff > SUM_W'(mipd_pkg::DIST_MAX)) ? mipd_pkg::DIST_MAX
                                                              : sum_ff[DIST_W-1:0];
   assign better = (pair_dist2 < best_dist2_ff);

   assign rsp_valid_in = (cmd.commit && last_ff) || (rsp_valid_ff && rsp_stall);
   assign status.last_pair = last_ff;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_row_ff[i] <= '0;
            best_disp_ff[i] <= '0;
         end
         best_dist2_ff <= mipd_pkg::DIST_MAX;
         ptag_ff <= mipd_pkg::MUL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptag_ff <= cmd.mul_op;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               mipd_pkg::CSR_BOX_ROW_X: box_row_ff[0] <= csr_wdata;
               mipd_pkg::CSR_BOX_ROW_Y: box_row_ff[1] <= csr_wdata;
               mipd_pkg::CSR_BOX_ROW_Z: box_row_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.commit) begin
            if (last_ff) begin
               best_dist2_ff <= mipd_pkg::DIST_MAX;
               for (int i = 0; i < 3; i++) begin
                  best_disp_ff[i] <= '0;
               end
            end else if (better) begin
               best_dist2_ff <= pair_dist2;
               for (int i = 0; i < 3; i++) begin
                  best_disp_ff[i] <= d_ff[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      sum_ff <= sum_in;
      if (cmd.load) begin
         last_ff <= req_last_pair;
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= d_new[i];
            w_ff[i] <= w_new[i];
         end
      end
      if (cmd.round_en) begin
         r_ff <= rnd[ACC_W-1:F];
      end
      if (cmd.commit && last_ff) begin
         rsp_dist_ff <= better ? pair_dist2 : best_dist2_ff;
         for (int i = 0; i < 3; i++) begin
            rsp_disp_ff[i] <= better ? d_ff[i] : best_disp_ff[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_min_dist2 = rsp_dist_ff;
   assign rsp_disp_a = rsp_disp_ff[0];
   assign rsp_disp_b = rsp_disp_ff[1];
   assign rsp_disp_c = rsp_disp_ff[2];

   a_run_cleared_after_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && last_ff) |=>
         (best_dist2_ff == mipd_pkg::DIST_MAX && best_disp_ff[0] == '0
          && best_disp_ff[1] == '0 && best_disp_ff[2] == '0))
      else $error("kept minimum not cleared after a result");

   a_word_only_from_commit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(cmd.commit && last_ff))
      else $error("result word appeared without a last pair commit");

endmodule

>>> hdl/min_image_closest_pair_distance.sv
// Closest-pair minimum-image distance between two molecules in a triclinic box.
// Request channel (req_*): one atom pair per word in scaled Q4.16 coordinates,
// with req_last_pair marking the final pair of a molecule pair. Response channel
// (rsp_*): one word per molecule pair, the smallest squared distance and the
// unwrapped scaled difference of the pair that gave it (first of equal wins).
// Both channels: a word moves on a clock edge with valid high and stall low.
// Box matrix rows are written on the csr_* port; the user must write them only
// while the block is idle, and the block itself does not enforce this. One
// shared multiplier forms each pair's nine matrix products and three squares
// in turn (six steps per box row), with accept, drain and compare cycles around
// them; req_stall is high while a pair is being worked on.
// The response sits in an output register, so the next pair is taken while a
// word waits; only a last pair whose word finds that register still stalled
// waits in its compare step until the receiver takes the earlier word.
// Synchronous reset clears the box rows to zero, drops rsp_valid and starts a
// fresh run with the kept distance at its largest value.
module min_image_closest_pair_distance #(
   parameter int COORD_FRAC_BITS = mipd_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_first_a,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_first_b,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_first_c,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_second_a,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_second_b,
   input  logic signed [mipd_pkg::IN_W-1:0]    req_second_c,
   input  logic                                req_last_pair,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mipd_pkg::DIST_W-1:0]         rsp_min_dist2,
   output logic signed [mipd_pkg::DISP_W-1:0]  rsp_disp_a,
   output logic signed [mipd_pkg::DISP_W-1:0]  rsp_disp_b,
   output logic signed [mipd_pkg::DISP_W-1:0]  rsp_disp_c,
   input  logic                                csr_write_en,
   input  logic [mipd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mipd_pkg::ROW_W-1:0]          csr_wdata
);

   mipd_pkg::dp_cmd_type    cmd;
   mipd_pkg::dp_status_type status;

   mipd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mipd_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_first_a   (req_first_a),
      .req_first_b   (req_first_b),
      .req_first_c   (req_first_c),
      .req_second_a  (req_second_a),
      .req_second_b  (req_second_b),
      .req_second_c  (req_second_c),
      .req_last_pair (req_last_pair),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_min_dist2 (rsp_min_dist2),
      .rsp_disp_a    (rsp_disp_a),
      .rsp_disp_b    (rsp_disp_b),
      .rsp_disp_c    (rsp_disp_c)
   );

endmodule

>>> dv/tb_min_image_closest_pair_distance.sv
module tb_min_image_closest_pair_distance;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [mipd_pkg::IN_W-1:0] coord_type;
   typedef logic signed [mipd_pkg::ENTRY_W-1:0] entry_type;
   typedef logic [mipd_pkg::ROW_W-1:0] row_type;

   typedef struct {
      coord_type first_a;
      coord_type first_b;
      coord_type first_c;
      coord_type second_a;
      coord_type second_b;
      coord_type second_c;
      logic      last_pair;
   } atom_pair_type;

   typedef struct {
      logic [mipd_pkg::DIST_W-1:0]        min_dist2;
      logic signed [mipd_pkg::DISP_W-1:0] disp_a;
      logic signed [mipd_pkg::DISP_W-1:0] disp_b;
      logic signed [mipd_pkg::DISP_W-1:0] disp_c;
   } closest_type;

   localparam int COORD_FRAC = mipd_pkg::COORD_FRAC_BITS_DEFAULT;
   localparam int ONE_CELL = 1 << COORD_FRAC;
   localparam int HALF_CELL = 1 << (COORD_FRAC - 1);
   localparam int COORD_LO = -(1 << (mipd_pkg::IN_W - 1));
   localparam int COORD_HI = (1 << (mipd_pkg::IN_W - 1)) - 1;
   localparam longint MAG_LIMIT = longint'(1) <<< 24;
   localparam logic [mipd_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam entry_type ENTRY_MAX = {1'b0, {(mipd_pkg::ENTRY_W-1){1'b1}}};
   localparam entry_type ENTRY_MIN = {1'b1, {(mipd_pkg::ENTRY_W-1){1'b0}}};
   localparam entry_type ENTRY_ONE = entry_type'(4096);
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_first_a = '0;
   coord_type req_first_b = '0;
   coord_type req_first_c = '0;
   coord_type req_second_a = '0;
   coord_type req_second_b = '0;
   coord_type req_second_c = '0;
   logic req_last_pair = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [mipd_pkg::DIST_W-1:0] rsp_min_dist2;
   logic signed [mipd_pkg::DISP_W-1:0] rsp_disp_a;
   logic signed [mipd_pkg::DISP_W-1:0] rsp_disp_b;
   logic signed [mipd_pkg::DISP_W-1:0] rsp_disp_c;
   logic csr_write_en = 1'b0;
   logic [mipd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   row_type csr_wdata = '0;

   // predictor state
   row_type box_rows [3] = '{default: '0};
   longint closest_dist2 = longint'(mipd_pkg::DIST_MAX);
   longint closest_disp [3] = '{default: 0};

   atom_pair_type pending_pairs [$];
   closest_type closest_q [$];
   atom_pair_type pair_on_bus;
   closest_type rsp_word;
   int err_cnt = 0;
   int cycle_cnt = 0;
   int send_gap = 0;
   int calm_left = 0;
   int drv_pick;
   int rcv_cycle = 0;
   int hold_left = 0;
   int stall_left = 0;
   int open_left = 0;
   int rcv_pick;

   min_image_closest_pair_distance DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_first_a   (req_first_a),
      .req_first_b   (req_first_b),
      .req_first_c   (req_first_c),
      .req_second_a  (req_second_a),
      .req_second_b  (req_second_b),
      .req_second_c  (req_second_c),
      .req_last_pair (req_last_pair),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_min_dist2 (rsp_min_dist2),
      .rsp_disp_a    (rsp_disp_a),
      .rsp_disp_b    (rsp_disp_b),
      .rsp_disp_c    (rsp_disp_c),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // folds one accepted pair into the running minimum, queues a word on the last pair
   function automatic void track_pair(input atom_pair_type p);
      longint diff [3];
      longint wrap [3];
      longint acc, r, mag, dist2, entry;
      bit over;
      closest_type word;
      diff[0] = longint'(p.second_a) - longint'(p.first_a);
      diff[1] = longint'(p.second_b) - longint'(p.first_b);
      diff[2] = longint'(p.second_c) - longint'(p.first_c);
      // nearest image, halfway rounds up
      for (int k = 0; k < 3; k++)
         wrap[k] = diff[k] - (((diff[k] + HALF_CELL) >>> COORD_FRAC) <<< COORD_FRAC);
      dist2 = 0;
      over = 1'b0;
      for (int k = 0; k < 3; k++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            entry = $signed(box_rows[k][mipd_pkg::ENTRY_W*j +: mipd_pkg::ENTRY_W]);
            acc += entry * wrap[j];
         end
         r = (acc + HALF_CELL) >>> COORD_FRAC;
         mag = (r < 0) ? -r : r;
         if (mag > MAG_LIMIT)
            over = 1'b1;
         else
            dist2 += mag * mag;
      end
      if (over || dist2 > longint'(mipd_pkg::DIST_MAX))
         dist2 = longint'(mipd_pkg::DIST_MAX);
      if (dist2 < closest_dist2) begin
         closest_dist2 = dist2;
         closest_disp = diff;
      end
      if (p.last_pair) begin
         word.min_dist2 = closest_dist2[mipd_pkg::DIST_W-1:0];
         word.disp_a = closest_disp[0][mipd_pkg::DISP_W-1:0];
         word.disp_b = closest_disp[1][mipd_pkg::DISP_W-1:0];
         word.disp_c = closest_disp[2][mipd_pkg::DISP_W-1:0];
         closest_q.push_back(word);
         closest_dist2 = longint'(mipd_pkg::DIST_MAX);
         closest_disp = '{default: 0};
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            track_pair(pair_on_bus);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               pair_on_bus = pending_pairs.pop_front();
               req_first_a <= pair_on_bus.first_a;
               req_first_b <= pair_on_bus.first_b;
               req_first_c <= pair_on_bus.first_c;
               req_second_a <= pair_on_bus.second_a;
               req_second_b <= pair_on_bus.second_b;
               req_second_c <= pair_on_bus.second_c;
               req_last_pair <= pair_on_bus.last_pair;
               req_valid <= 1'b1;
               if (calm_left > 0) begin
                  calm_left--;
               end else begin
                  drv_pick = $urandom_range(0, 99);
                  if (drv_pick < 4)
                     calm_left = 40;
                  else if (drv_pick >= 60 && drv_pick < 95)
                     send_gap = $urandom_range(1, 3);
                  else if (drv_pick >= 95)
                     send_gap = $urandom_range(20, 80);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall: random short and long stalls, open stretches, and a periodic
   // long hold so the block backs up into its input
   always @(posedge clock) begin
      rcv_cycle++;
      if (rcv_cycle % 4000 == 0)
         hold_left = 350;
      if (hold_left == 0 && stall_left == 0 && open_left == 0) begin
         rcv_pick = $urandom_range(0, 99);
         if (rcv_pick < 55)
            open_left = $urandom_range(1, 30);
         else if (rcv_pick < 95)
            stall_left = $urandom_range(1, 4);
         else
            stall_left = $urandom_range(15, 60);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         open_left--;
         rsp_stall <= 1'b0;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (closest_q.size() == 0) begin
            $error("unexpected word: min_dist2 %0d disp %0d %0d %0d",
                   rsp_min_dist2, rsp_disp_a, rsp_disp_b, rsp_disp_c);
            err_cnt++;
         end else begin
            rsp_word = closest_q.pop_front();
            if (rsp_min_dist2 !== rsp_word.min_dist2) begin
               $error("min_dist2: expected %0d, got %0d", rsp_word.min_dist2, rsp_min_dist2);
               err_cnt++;
            end
            if (rsp_disp_a !== rsp_word.disp_a) begin
               $error("disp_a: expected %0d, got %0d", rsp_word.disp_a, rsp_disp_a);
               err_cnt++;
            end
            if (rsp_disp_b !== rsp_word.disp_b) begin
               $error("disp_b: expected %0d, got %0d", rsp_word.disp_b, rsp_disp_b);
               err_cnt++;
            end
            if (rsp_disp_c !== rsp_word.disp_c) begin
               $error("disp_c: expected %0d, got %0d", rsp_word.disp_c, rsp_disp_c);
               err_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("** min_image_closest_pair_distance: FAILED **");
         $finish;
      end
   end

   function automatic row_type pack_row(input entry_type col_a, input entry_type col_b,
                                        input entry_type col_c);
      return {col_c, col_b, col_a};
   endfunction

   function automatic entry_type skew_entry();
      return entry_type'(int'($urandom_range(0, 8192)) - 4096);
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? coord_type'(COORD_HI) : coord_type'(COORD_LO);
         1, 2, 3, 4, 5: return coord_type'($urandom_range(0, ONE_CELL - 1));
         default: return coord_type'($urandom);
      endcase
   endfunction

   // moves a coordinate by delta when the result still fits the field
   function automatic coord_type nudge(input coord_type v, input longint delta);
      longint moved;
      moved = longint'(v) + delta;
      if (moved < COORD_LO || moved > COORD_HI)
         return v;
      return coord_type'(moved);
   endfunction

   task automatic add_pair(input int fa, input int fb, input int fc,
                           input int sa, input int sb, input int sc, input bit last);
      atom_pair_type p;
      p.first_a = coord_type'(fa);
      p.first_b = coord_type'(fb);
      p.first_c = coord_type'(fc);
      p.second_a = coord_type'(sa);
      p.second_b = coord_type'(sb);
      p.second_c = coord_type'(sc);
      p.last_pair = last;
      pending_pairs.push_back(p);
   endtask

   task automatic queue_random_runs(input int n_pairs);
      int queued, run_len, kind;
      longint odd [3];
      atom_pair_type p;
      queued = 0;
      while (queued < n_pairs) begin
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
         for (int k = 0; k < run_len; k++) begin
            kind = $urandom_range(0, 9);
            if (k > 0 && kind < 2) begin
               // image of the previous pair: same distance, unwrapped difference moved by up to two cells per axis
               p.second_a = nudge(p.second_a, longint'(int'($urandom_range(0, 4)) - 2) * ONE_CELL);
               p.second_b = nudge(p.second_b, longint'(int'($urandom_range(0, 4)) - 2) * ONE_CELL);
               p.second_c = nudge(p.second_c, longint'(int'($urandom_range(0, 4)) - 2) * ONE_CELL);
            end else if (kind == 2) begin
               // difference an odd multiple of half a cell
               for (int j = 0; j < 3; j++)
                  odd[j] = longint'(2 * int'($urandom_range(0, 3)) - 3) * HALF_CELL;
               p.first_a = coord_type'($urandom_range(0, ONE_CELL - 1));
               p.first_b = coord_type'($urandom_range(0, ONE_CELL - 1));
               p.first_c = coord_type'($urandom_range(0, ONE_CELL - 1));
               p.second_a = nudge(p.first_a, odd[0]);
               p.second_b = nudge(p.first_b, odd[1]);
               p.second_c = nudge(p.first_c, odd[2]);
            end else begin
               p.first_a = rand_coord();
               p.first_b = rand_coord();
               p.first_c = rand_coord();
               p.second_a = rand_coord();
               p.second_b = rand_coord();
               p.second_c = rand_coord();
            end
            p.last_pair = (k == run_len - 1);
            pending_pairs.push_back(p);
            queued++;
         end
      end
   endtask

   task automatic write_row(input logic [mipd_pkg::CSR_IDX_W-1:0] idx, input row_type value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx != CSR_UNUSED)
         box_rows[idx] = value;
   endtask

   task automatic load_box(input row_type row_x, input row_type row_y, input row_type row_z);
      write_row(mipd_pkg::CSR_BOX_ROW_X, row_x);
      write_row(CSR_UNUSED, row_type'({$urandom, $urandom}));
      write_row(mipd_pkg::CSR_BOX_ROW_Y, row_y);
      write_row(mipd_pkg::CSR_BOX_ROW_Z, row_z);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // every word sent and answered, then room for a pair still in the datapath
   task automatic wait_idle();
      @(negedge clock);
      while (pending_pairs.size() != 0 || req_valid || closest_q.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // box still zero after reset: every distance ties, the first pair wins
      add_pair(COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO, 1'b0);
      add_pair(5, 6, 7, -5, -6, -7, 1'b0);
      add_pair(100, 200, 300, 400, 500, 600, 1'b1);
      wait_idle();

      load_box(pack_row(ENTRY_ONE, '0, '0), pack_row('0, ENTRY_ONE, '0),
               pack_row('0, '0, ENTRY_ONE));
      add_pair(0, 0, 0, 0, 0, 0, 1'b0);
      add_pair(0, 0, 0, ONE_CELL, ONE_CELL, ONE_CELL, 1'b1);
      add_pair(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, 1'b1);
      add_pair(COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO, 1'b1);
      add_pair(0, 0, 0, HALF_CELL, -HALF_CELL, 3 * HALF_CELL, 1'b1);
      add_pair(0, 0, 0, -3 * HALF_CELL, HALF_CELL, -HALF_CELL, 1'b1);
      add_pair(1000, 2000, 3000, 21000, 2000, 3000, 1'b0);
      add_pair(1000, 2000, 3000, 11000, 2000, 3000, 1'b0);
      add_pair(1000, 2000, 3000, 11000 + ONE_CELL, 2000 - ONE_CELL, 3000, 1'b0);
      add_pair(-1, -1, -1, 0, 0, 0, 1'b1);
      add_pair(COORD_LO, 0, COORD_HI, COORD_LO + HALF_CELL, HALF_CELL, COORD_HI, 1'b1);
      wait_idle();

      load_box(pack_row(entry_type'($urandom_range(8192, 40960)), skew_entry(), skew_entry()),
               pack_row(skew_entry(), entry_type'($urandom_range(8192, 40960)), skew_entry()),
               pack_row(skew_entry(), skew_entry(), entry_type'($urandom_range(8192, 40960))));
      queue_random_runs(300);
      wait_idle();

      load_box(pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX), pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX),
               pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
      queue_random_runs(150);
      wait_idle();

      load_box(pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN), pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN),
               pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
      queue_random_runs(150);
      wait_idle();

      load_box('1, '1, '1);
      queue_random_runs(150);
      wait_idle();

      load_box(row_type'({$urandom, $urandom}), row_type'({$urandom, $urandom}),
               row_type'({$urandom, $urandom}));
      queue_random_runs(300);
      wait_idle();

      load_box('0, '0, '0);
      queue_random_runs(150);
      wait_idle();

      if (err_cnt == 0)
         $display("** min_image_closest_pair_distance: PASSED **");
      else
         $display("** min_image_closest_pair_distance: FAILED **");
      $finish;
   end

endmodule
